[src/assert_macros.svh]
// Assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define PPG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define PPG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PPG_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define PPG_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/ppg_ftd_pkg.sv]
package ppg_ftd_pkg;

    localparam int CHANNELS_DEF    = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int WORD_W     = 32;
    localparam int DIFF_W     = WORD_W + 1;
    localparam int DAC_W      = 8;
    localparam int GAIN_W     = 2 * DAC_W;
    localparam int PROD_W     = 49;
    localparam int SHIFT      = 20;
    localparam int LEVEL_W    = PROD_W - SHIFT;
    localparam int THR_W      = 20;
    localparam int RUN_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [THR_W-1:0] UPPER_RST = 20'd600;
    localparam logic [THR_W-1:0] LOWER_RST = 20'd512;
    localparam logic [RUN_W-1:0] LIMIT_RST = 8'd3;
    localparam logic [RUN_W-1:0] RUN_MAX   = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LED_DAC       = 3'd0,
        REG_EXPOSURE      = 3'd1,
        REG_UPPER_THR     = 3'd2,
        REG_LOWER_THR     = 3'd3,
        REG_TOUCH_LIMIT   = 3'd4,
        REG_RELEASE_LIMIT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_W-1:0] sample_word;
        logic              last_word;
        logic [WORD_W-1:0] received_checksum;
    } in_t;

    typedef struct packed {
        logic touch_detected;
        logic checksum_ok;
    } out_t;

    typedef struct packed {
        logic                     has_diff;
        logic signed [DIFF_W-1:0] diff;
        logic                     is_last;
        logic                     csum_ok;
    } job_t;

    typedef struct packed {
        logic [DAC_W-1:0] led_dac;
        logic [DAC_W-1:0] exposure;
        logic [THR_W-1:0] upper_threshold;
        logic [THR_W-1:0] lower_threshold;
        logic [RUN_W-1:0] touch_run_limit;
        logic [RUN_W-1:0] release_run_limit;
    } cfg_t;

    typedef struct packed {
        logic [RUN_W-1:0] touch_run;
        logic [RUN_W-1:0] release_run;
        logic             idle;
    } back_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_MUL   = 2'd1,
        BK_HYST  = 2'd2,
        BK_FRAME = 2'd3
    } back_state_t;

endpackage

[src/ppg_ftd_front.sv]
module ppg_ftd_front #(
    parameter int CHANNELS = ppg_ftd_pkg::CHANNELS_DEF,
    localparam int POS_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_ready,
    input  ppg_ftd_pkg::in_t       sample,
    input  logic                   full,
    output logic                   push,
    output ppg_ftd_pkg::job_t      job,
    output logic [POS_W-1:0]       pos
);

    localparam logic [POS_W-1:0] POS_FIRST  = '0;
    localparam logic [POS_W-1:0] POS_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(CHANNELS - 1);

    logic [POS_W-1:0]                   pos_reg, pos_next;
    logic [ppg_ftd_pkg::WORD_W-1:0]     hold_reg, hold_next;
    logic [ppg_ftd_pkg::WORD_W-1:0]     xor_reg, xor_next;
    logic [ppg_ftd_pkg::WORD_W-1:0]     xor_cur;
    logic                               accept;

    assign sample_ready = !full;
    assign accept       = sample_valid && !full;
    assign xor_cur      = xor_reg ^ sample.sample_word;
    assign pos          = pos_reg;

    always_comb
    begin
        job.has_diff = (pos_reg == POS_SECOND);
        job.diff     = $signed({hold_reg[ppg_ftd_pkg::WORD_W-1], hold_reg})
                     - $signed({sample.sample_word[ppg_ftd_pkg::WORD_W-1],
                                sample.sample_word});
        job.is_last  = sample.last_word;
        job.csum_ok  = (xor_cur == sample.received_checksum);
    end

    assign push = accept && (job.has_diff || job.is_last);

    always_comb
    begin
        pos_next  = pos_reg;
        hold_next = hold_reg;
        xor_next  = xor_reg;
        if (accept)
        begin
            if (pos_reg == POS_FIRST)
            begin
                hold_next = sample.sample_word;
            end
            if (sample.last_word)
            begin
                pos_next = POS_FIRST;
                xor_next = '0;
            end
            else
            begin
                pos_next = (pos_reg == POS_LAST) ? POS_FIRST : pos_reg + POS_W'(1);
                xor_next = xor_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            hold_reg <= '0;
            xor_reg  <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            hold_reg <= hold_next;
            xor_reg  <= xor_next;
        end
    end

endmodule

[src/ppg_ftd_queue.sv]
module ppg_ftd_queue #(
    parameter int DEPTH = ppg_ftd_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ppg_ftd_pkg::job_t   job_in,
    input  logic                pop,
    output ppg_ftd_pkg::job_t   job_out,
    output logic                empty,
    output logic                full,
    output logic [CNT_W-1:0]    count
);

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ppg_ftd_pkg::job_t   entries_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_FULL);
    assign count   = count_reg;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign job_out = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/ppg_ftd_back.sv]
module ppg_ftd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ppg_ftd_pkg::cfg_t           cfg,
    input  logic                        empty,
    output logic                        pop,
    input  ppg_ftd_pkg::job_t           job,
    output logic                        result_valid,
    input  logic                        result_ready,
    output ppg_ftd_pkg::out_t           result,
    output ppg_ftd_pkg::back_stat_t     stat
);

    localparam int PROD_W  = ppg_ftd_pkg::PROD_W;
    localparam int LEVEL_W = ppg_ftd_pkg::LEVEL_W;
    localparam int RUN_W   = ppg_ftd_pkg::RUN_W;
    localparam int FULL_W  = ppg_ftd_pkg::DIFF_W + ppg_ftd_pkg::GAIN_W + 1;

    ppg_ftd_pkg::back_state_t           state_reg, state_next;
    ppg_ftd_pkg::job_t                  job_reg, job_next;
    logic [ppg_ftd_pkg::GAIN_W-1:0]     gain_reg;
    logic signed [PROD_W-1:0]           prod_reg, prod_next;
    logic [RUN_W-1:0]                   touch_run_reg, touch_run_next;
    logic [RUN_W-1:0]                   release_run_reg, release_run_next;
    logic                               status_reg, status_next;
    logic                               res_valid_reg, res_valid_next;
    ppg_ftd_pkg::out_t                  res_reg, res_next;
    logic signed [FULL_W-1:0]           prod_full;
    logic signed [LEVEL_W-1:0]          level;
    logic signed [LEVEL_W-1:0]          upper_s, lower_s;

    // |diff| < 2^32 and gain < 2^16, so the product fits in PROD_W bits
    assign prod_full = job_reg.diff * $signed({1'b0, gain_reg});
    // arithmetic shift of the two's complement product is the floor
    assign level     = prod_reg[PROD_W-1:ppg_ftd_pkg::SHIFT];
    assign upper_s   = $signed({{(LEVEL_W - ppg_ftd_pkg::THR_W){1'b0}},
                                cfg.upper_threshold});
    assign lower_s   = $signed({{(LEVEL_W - ppg_ftd_pkg::THR_W){1'b0}},
                                cfg.lower_threshold});

    assign pop               = (state_reg == ppg_ftd_pkg::BK_IDLE) && !empty;
    assign result_valid      = res_valid_reg;
    assign result            = res_reg;
    assign stat.touch_run    = touch_run_reg;
    assign stat.release_run  = release_run_reg;
    assign stat.idle         = (state_reg == ppg_ftd_pkg::BK_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        job_next         = job_reg;
        prod_next        = prod_reg;
        touch_run_next   = touch_run_reg;
        release_run_next = release_run_reg;
        status_next      = status_reg;
        res_valid_next   = res_valid_reg && !result_ready;
        res_next         = res_reg;
        case (state_reg)
            ppg_ftd_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    job_next   = job;
                    state_next = job.has_diff ? ppg_ftd_pkg::BK_MUL : ppg_ftd_pkg::BK_FRAME;
                end
            end
            ppg_ftd_pkg::BK_MUL:
            begin
                prod_next  = prod_full[PROD_W-1:0];
                state_next = ppg_ftd_pkg::BK_HYST;
            end
            ppg_ftd_pkg::BK_HYST:
            begin
                if (level > upper_s)
                begin
                    if (touch_run_reg != ppg_ftd_pkg::RUN_MAX)
                    begin
                        touch_run_next = touch_run_reg + RUN_W'(1);
                    end
                    release_run_next = '0;
                end
                else if (level < lower_s)
                begin
                    if (release_run_reg != ppg_ftd_pkg::RUN_MAX)
                    begin
                        release_run_next = release_run_reg + RUN_W'(1);
                    end
                    touch_run_next = '0;
                end
                else
                begin
                    touch_run_next   = '0;
                    release_run_next = '0;
                end
                state_next = job_reg.is_last ? ppg_ftd_pkg::BK_FRAME : ppg_ftd_pkg::BK_IDLE;
            end
            ppg_ftd_pkg::BK_FRAME:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    if (touch_run_reg > cfg.touch_run_limit)
                    begin
                        status_next = 1'b1;
                    end
                    else if (release_run_reg > cfg.release_run_limit)
                    begin
                        status_next = 1'b0;
                    end
                    res_next.touch_detected = status_next;
                    res_next.checksum_ok    = job_reg.csum_ok;
                    res_valid_next          = 1'b1;
                    state_next              = ppg_ftd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ppg_ftd_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        gain_reg <= ppg_ftd_pkg::GAIN_W'(cfg.led_dac) * ppg_ftd_pkg::GAIN_W'(cfg.exposure);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ppg_ftd_pkg::BK_IDLE;
            touch_run_reg   <= '0;
            release_run_reg <= '0;
            status_reg      <= 1'b1;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            touch_run_reg   <= touch_run_next;
            release_run_reg <= release_run_next;
            status_reg      <= status_next;
            res_valid_reg   <= res_valid_next;
        end
    end

endmodule

[src/ppg_frame_touch_detector.sv]
// Flow: the last word of a frame goes into the job queue, is popped by the back end
// and yields its result in the frame step, with multiply and hysteresis first when it
// completes a record. Throughput: one word per cycle while the job queue has room; the
// back end takes each record through pop, multiply and hysteresis, plus a result step
// at a frame end, or through pop and result when the last word completes no record.
// Reset (rst_n, async, active low): counters and queue cleared, touch status 1,
// config registers to their defaults.
`include "assert_macros.svh"

module ppg_frame_touch_detector #(
    parameter int CHANNELS    = ppg_ftd_pkg::CHANNELS_DEF,
    parameter int QUEUE_DEPTH = ppg_ftd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  ppg_ftd_pkg::in_t                    sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output ppg_ftd_pkg::out_t                   result,
    input  logic                                cfg_we,
    input  logic [ppg_ftd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ppg_ftd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int POS_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    ppg_ftd_pkg::cfg_t          cfg_reg;
    ppg_ftd_pkg::job_t          front_job, queue_job;
    ppg_ftd_pkg::back_stat_t    back_stat;
    logic                       q_push, q_pop, q_empty, q_full;
    logic [CNT_W-1:0]           q_count;
    logic [POS_W-1:0]           front_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.led_dac           <= '0;
            cfg_reg.exposure          <= '0;
            cfg_reg.upper_threshold   <= ppg_ftd_pkg::UPPER_RST;
            cfg_reg.lower_threshold   <= ppg_ftd_pkg::LOWER_RST;
            cfg_reg.touch_run_limit   <= ppg_ftd_pkg::LIMIT_RST;
            cfg_reg.release_run_limit <= ppg_ftd_pkg::LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppg_ftd_pkg::REG_LED_DAC:       cfg_reg.led_dac           <= cfg_wdata[7:0];
                ppg_ftd_pkg::REG_EXPOSURE:      cfg_reg.exposure          <= cfg_wdata[7:0];
                ppg_ftd_pkg::REG_UPPER_THR:     cfg_reg.upper_threshold   <= cfg_wdata;
                ppg_ftd_pkg::REG_LOWER_THR:     cfg_reg.lower_threshold   <= cfg_wdata;
                ppg_ftd_pkg::REG_TOUCH_LIMIT:   cfg_reg.touch_run_limit   <= cfg_wdata[7:0];
                ppg_ftd_pkg::REG_RELEASE_LIMIT: cfg_reg.release_run_limit <= cfg_wdata[7:0];
                default:                        cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    ppg_ftd_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .full         (q_full),
        .push         (q_push),
        .job          (front_job),
        .pos          (front_pos)
    );

    ppg_ftd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .job_in  (front_job),
        .pop     (q_pop),
        .job_out (queue_job),
        .empty   (q_empty),
        .full    (q_full),
        .count   (q_count)
    );

    ppg_ftd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .empty        (q_empty),
        .pop          (q_pop),
        .job          (queue_job),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .stat         (back_stat)
    );

    // a record can only extend one of the two runs
    `PPG_ASSERT_IMPLIES(a_runs_exclusive, clk, rst_n, 1'b1,
        (back_stat.touch_run == '0) || (back_stat.release_run == '0))

    `PPG_ASSERT_IMPLIES(a_queue_bound, clk, rst_n, 1'b1, int'(q_count) <= QUEUE_DEPTH)

    `PPG_ASSERT_IMPLIES(a_pos_range, clk, rst_n, 1'b1, int'(front_pos) < CHANNELS)

    // nothing queued and nothing in flight: no transaction can appear next cycle
    `PPG_ASSERT_NEXT(a_no_spurious_result, clk, rst_n,
        q_empty && back_stat.idle && !result_valid, !result_valid)

endmodule
